// ----- sv/fwec_pkg.sv -----
// Shared types, sizes and codes for the five-wire efficiency counter.
// No dependencies; used by five_wire_efficiency_counter_unit.
package fwec_pkg;

  localparam int WIRES      = 279;
  localparam int PLANES     = 4;
  localparam int PACKAGES   = 2;
  localparam int COUNT_BITS = 32;

  localparam int CELLS   = PACKAGES * PLANES * WIRES;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int WIRE_W  = 9;
  localparam int PLANE_W = 3;
  localparam int PKG_W   = 2;
  localparam int TIME_W  = 16;
  localparam int OUT_W   = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic signed [TIME_W-1:0] WIN_LO_RST = -16'sd10;
  localparam logic signed [TIME_W-1:0] WIN_HI_RST = 16'sd400;
  localparam logic [2:0]               REGION_RST = 3'd3;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CELL_W-1:0]     cell_t;

  typedef enum logic [1:0] {
    MODE_STORE = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_READ  = 2'd0,
    STAT_SCAN  = 2'd1,
    STAT_BAD   = 2'd2,
    STAT_CLEAR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_WIN_LO = 2'd0,
    REG_WIN_HI = 2'd1,
    REG_REGION = 2'd2
  } reg_idx_t;

  typedef struct packed {
    mode_t                     mode;
    logic [2:0]                region_id;
    logic [PKG_W-1:0]          package_id;
    logic [PLANE_W-1:0]        plane_id;
    logic [WIRE_W-1:0]         wire_id;
    logic [3:0]                hit_order;
    logic signed [TIME_W-1:0]  hit_time;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] trigger_count;
    logic [OUT_W-1:0] fire_count;
  } out_word_t;

  typedef struct packed {
    logic                     present;
    logic signed [TIME_W-1:0] t;
  } hit_ent_t;

  typedef struct packed {
    count_t trig;
    count_t fire;
  } cnt_ent_t;

  function automatic logic index_ok(logic [PKG_W-1:0] pkg, logic [PLANE_W-1:0] pl,
                                    logic [WIRE_W-1:0] w);
    return (int'(pkg) >= 1) && (int'(pkg) <= PACKAGES) &&
           (int'(pl) >= 1) && (int'(pl) <= PLANES) &&
           (int'(w) >= 1) && (int'(w) <= WIRES);
  endfunction

  function automatic cell_t cell_index(logic [PKG_W-1:0] pkg, logic [PLANE_W-1:0] pl,
                                       logic [WIRE_W-1:0] w);
    cell_t p;
    cell_t l;
    cell_t x;
    p = CELL_W'(pkg) - CELL_W'(1);
    l = CELL_W'(pl) - CELL_W'(1);
    x = CELL_W'(w) - CELL_W'(1);
    return CELL_W'((p * CELL_W'(PLANES) + l) * CELL_W'(WIRES) + x);
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] clamp_out(count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[OUT_W-1:0];
  endfunction

endpackage

// ----- sv/five_wire_efficiency_counter_unit.sv -----
// Five-wire efficiency counter: hit store, end-of-event scan and per-wire counters.
// Depends on fwec_pkg (types, sizes, codes, index and counter helpers).

// A store word leaves busy low. A read of a valid wire holds busy in the read state;
// the counter entry and then the result are registered before the strobe; a read of a bad index
// strobes status 2 on the next cycle. An end-of-event scan walks all CELLS (2232)
// wires at one wire per cycle through the single read port of the hit store, then
// drains a three-stage pipeline; the result strobe rises as busy falls.
// A counter clear sweeps the counter memory one entry a cycle.
// After reset a clearing pass empties the hit store and counters with
// busy high; configuration writes are taken meanwhile. The result strobe lasts one
// cycle and cannot be stalled by the receiver.
module five_wire_efficiency_counter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  fwec_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output fwec_pkg::out_word_t           out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwec_pkg::ADDR_W-1:0]   paddr,
  input  logic [fwec_pkg::DATA_W-1:0]   pwdata,
  output logic [fwec_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_CLEAR = 6'b010000,
    ST_READ  = 6'b100000
  } state_t;

  localparam int          WIN_N      = 5;
  localparam logic [1:0]  DRAIN_LAST = 2'd2;
  localparam fwec_pkg::cell_t LAST_CELL = fwec_pkg::CELL_W'(fwec_pkg::CELLS - 1);
  localparam logic [fwec_pkg::WIRE_W-1:0] LAST_WIRE =
    fwec_pkg::WIRE_W'(fwec_pkg::WIRES - 1);
  localparam logic [fwec_pkg::WIRE_W-1:0] FIRST_FULL = fwec_pkg::WIRE_W'(WIN_N - 1);

  // configuration
  logic signed [fwec_pkg::TIME_W-1:0] win_lo_r;
  logic signed [fwec_pkg::TIME_W-1:0] win_hi_r;
  logic [2:0]                         region_r;
  logic                               cfg_wr;

  // sequencer
  state_t                       state_r, state_nxt;
  fwec_pkg::cell_t              cell_r, cell_nxt;
  logic [fwec_pkg::WIRE_W-1:0]  wire_r, wire_nxt;
  logic [1:0]                   drain_r, drain_nxt;

  // scan pipeline
  logic                         s1_vld_r;
  logic [fwec_pkg::WIRE_W-1:0]  s1_wire_r;
  fwec_pkg::cell_t              s1_cell_r;
  logic                         s2_vld_r;
  fwec_pkg::cell_t              s2_cell_r;
  logic                         s3_vld_r;
  logic                         s3_fire_r;
  fwec_pkg::cell_t              s3_cell_r;
  logic                         win_ok_r [WIN_N];
  logic signed [fwec_pkg::TIME_W-1:0] win_t_r [WIN_N];
  logic                         new_ok;
  logic                         trig;

  // memories
  fwec_pkg::hit_ent_t hit_mem [fwec_pkg::CELLS];
  fwec_pkg::cnt_ent_t cnt_mem [fwec_pkg::CELLS];
  fwec_pkg::hit_ent_t hit_rd_r;
  fwec_pkg::cnt_ent_t cnt_rd_r;
  logic               hit_we;
  fwec_pkg::cell_t    hit_waddr;
  fwec_pkg::hit_ent_t hit_wdata;
  logic               cnt_we;
  fwec_pkg::cell_t    cnt_waddr;
  fwec_pkg::cnt_ent_t cnt_wdata;
  fwec_pkg::cell_t    cnt_raddr;

  // input decode
  logic                accept;
  logic                in_ok;
  fwec_pkg::cell_t     in_cell;
  logic                store_ok;

  // result
  logic                out_valid_r, out_valid_nxt;
  fwec_pkg::out_word_t out_word_r, out_word_nxt;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_lo_r <= fwec_pkg::WIN_LO_RST;
      win_hi_r <= fwec_pkg::WIN_HI_RST;
      region_r <= fwec_pkg::REGION_RST;
    end else if (cfg_wr) begin
      case (fwec_pkg::reg_idx_t'(paddr[3:2]))
        fwec_pkg::REG_WIN_LO: win_lo_r <= pwdata[fwec_pkg::TIME_W-1:0];
        fwec_pkg::REG_WIN_HI: win_hi_r <= pwdata[fwec_pkg::TIME_W-1:0];
        fwec_pkg::REG_REGION: region_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fwec_pkg::reg_idx_t'(paddr[3:2]))
      fwec_pkg::REG_WIN_LO: prdata = fwec_pkg::DATA_W'(win_lo_r);
      fwec_pkg::REG_WIN_HI: prdata = fwec_pkg::DATA_W'(win_hi_r);
      fwec_pkg::REG_REGION: prdata = fwec_pkg::DATA_W'(region_r);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input decode
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && (state_r == ST_IDLE);
  assign in_ok    = fwec_pkg::index_ok(in_word.package_id, in_word.plane_id, in_word.wire_id);
  assign in_cell  = fwec_pkg::cell_index(in_word.package_id, in_word.plane_id,
                                         in_word.wire_id);
  assign store_ok = accept && (in_word.mode == fwec_pkg::MODE_STORE) &&
                    (in_word.region_id == region_r) && (in_word.hit_order == 4'd0) && in_ok;

  // ---------------------------------------------------------------- hit store
  always_comb begin
    hit_we    = 1'b0;
    hit_waddr = cell_r;
    hit_wdata = '0;
    if (state_r == ST_INIT || state_r == ST_SCAN) begin
      // drop each wire behind the scan read
      hit_we = 1'b1;
    end else if (store_ok) begin
      hit_we    = 1'b1;
      hit_waddr = in_cell;
      hit_wdata = '{present: 1'b1, t: in_word.hit_time};
    end
  end

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_waddr] <= hit_wdata;
    end
    hit_rd_r <= hit_mem[cell_r];
  end

  // ---------------------------------------------------------------- scan pipeline
  assign new_ok = hit_rd_r.present && (hit_rd_r.t > win_lo_r) && (hit_rd_r.t < win_hi_r);

  // window slot 2 is the center wire, 0/1 below it, 3/4 above it
  assign trig = s2_vld_r && win_ok_r[0] && win_ok_r[1] && win_ok_r[3] && win_ok_r[4] &&
                (win_t_r[0] > win_t_r[1]) && (win_t_r[4] > win_t_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_SCAN);
      s2_vld_r <= s1_vld_r && (s1_wire_r >= FIRST_FULL);
      s3_vld_r <= trig;
    end
  end

  always_ff @(posedge clk) begin
    s1_wire_r <= wire_r;
    s1_cell_r <= cell_r;
    s2_cell_r <= s1_cell_r - fwec_pkg::CELL_W'(2);
    s3_cell_r <= s2_cell_r;
    s3_fire_r <= win_ok_r[2];
    if (s1_vld_r) begin
      for (int i = 0; i < WIN_N - 1; i++) begin
        win_ok_r[i] <= win_ok_r[i+1];
        win_t_r[i]  <= win_t_r[i+1];
      end
      win_ok_r[WIN_N-1] <= new_ok;
      win_t_r[WIN_N-1]  <= hit_rd_r.t;
    end
  end

  // ---------------------------------------------------------------- counters
  assign cnt_raddr = (state_r == ST_IDLE) ? in_cell : s2_cell_r;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cell_r;
    cnt_wdata = '0;
    if (state_r == ST_INIT || state_r == ST_CLEAR) begin
      cnt_we = 1'b1;
    end else if (s3_vld_r) begin
      cnt_we         = 1'b1;
      cnt_waddr      = s3_cell_r;
      cnt_wdata.trig = fwec_pkg::sat_inc(cnt_rd_r.trig);
      cnt_wdata.fire = s3_fire_r ? fwec_pkg::sat_inc(cnt_rd_r.fire) : cnt_rd_r.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    cell_nxt      = cell_r;
    wire_nxt      = wire_r;
    drain_nxt     = drain_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_word.mode)
            fwec_pkg::MODE_STORE: ;
            fwec_pkg::MODE_SCAN: begin
              state_nxt = ST_SCAN;
              cell_nxt  = '0;
              wire_nxt  = '0;
            end
            fwec_pkg::MODE_READ: begin
              if (in_ok) begin
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt       = 1'b1;
                out_word_nxt.status = fwec_pkg::STAT_BAD;
              end
            end
            fwec_pkg::MODE_CLEAR: begin
              state_nxt = ST_CLEAR;
              cell_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_INIT, ST_CLEAR: begin
        cell_nxt = cell_r + fwec_pkg::CELL_W'(1);
        if (cell_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
          if (state_r == ST_CLEAR) begin
            out_valid_nxt       = 1'b1;
            out_word_nxt.status = fwec_pkg::STAT_CLEAR;
          end
        end
      end
      ST_SCAN: begin
        cell_nxt = cell_r + fwec_pkg::CELL_W'(1);
        wire_nxt = (wire_r == LAST_WIRE) ? '0 : wire_r + fwec_pkg::WIRE_W'(1);
        if (cell_r == LAST_CELL) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end
      end
      ST_DRAIN: begin
        // hold until the last counter update is written
        drain_nxt = drain_r + 2'd1;
        if (drain_r == DRAIN_LAST) begin
          state_nxt           = ST_IDLE;
          out_valid_nxt       = 1'b1;
          out_word_nxt.status = fwec_pkg::STAT_SCAN;
        end
      end
      ST_READ: begin
        state_nxt                  = ST_IDLE;
        out_valid_nxt              = 1'b1;
        out_word_nxt.status        = fwec_pkg::STAT_READ;
        out_word_nxt.trigger_count = fwec_pkg::clamp_out(cnt_rd_r.trig);
        out_word_nxt.fire_count    = fwec_pkg::clamp_out(cnt_rd_r.fire);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cell_r      <= '0;
      wire_r      <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cell_r      <= cell_nxt;
      wire_r      <= wire_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.mode == fwec_pkg::MODE_STORE) |=> !out_valid)
    else $error("store word produced a result");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.mode == fwec_pkg::MODE_SCAN) |=> busy)
    else $error("scan did not raise busy");

  a_cnt_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("counter update outside of scan");
`endif

endmodule

// ----- sim/five_wire_efficiency_counter_unit_tb.sv -----
// Self-checking testbench for the five-wire efficiency counter: random hit events,
// scans, counter reads and clears, checked against an in-bench copy of the counters.
// Depends on fwec_pkg and five_wire_efficiency_counter_unit.
`timescale 1ns / 1ps

module five_wire_efficiency_counter_unit_tb;
  import fwec_pkg::*;

  localparam int PHASE_WORDS = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_word_t            in_word = '0;
  logic                out_valid;
  out_word_t           out_word;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Copy of the block's state
  logic signed [TIME_W-1:0] win_lo = WIN_LO_RST;
  logic signed [TIME_W-1:0] win_hi = WIN_HI_RST;
  logic [2:0]               keep_region = REGION_RST;
  bit                       hit_seen [CELLS];
  bit signed [TIME_W-1:0]   hit_ns [CELLS];
  bit [COUNT_BITS-1:0]      trig_tally [CELLS];
  bit [COUNT_BITS-1:0]      fire_tally [CELLS];

  in_word_t  pending_words [$];
  out_word_t owed_results [$];

  bit word_taken;
  int idle_left = 0;
  int steady_left = 0;
  int cycles = 0;
  int budget = 4 * (CELLS + 200);
  int faults = 0;
  int phase_items = 0;
  int n_store = 0, n_scan = 0, n_read = 0, n_clear = 0;
  int trig_reads = 0, fire_reads = 0, settings_done = 0;

  five_wire_efficiency_counter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  function automatic bit spot_ok(int pkg, int pl, int wno);
    return pkg >= 1 && pkg <= PACKAGES && pl >= 1 && pl <= PLANES && wno >= 1 && wno <= WIRES;
  endfunction

  function automatic bit timed_in_window(int c);
    return hit_seen[c] && hit_ns[c] > win_lo && hit_ns[c] < win_hi;
  endfunction

  // Apply one accepted word to the counter copy and queue the result it owes
  task automatic advance_counters(in_word_t w);
    out_word_t res;
    int        c, row, x, pkg, pl, wno;
    pkg = int'(w.package_id);
    pl  = int'(w.plane_id);
    wno = int'(w.wire_id);
    c   = ((pkg - 1) * PLANES + (pl - 1)) * WIRES + (wno - 1);
    res = '0;
    case (w.mode)
      MODE_STORE: begin
        if (w.region_id == keep_region && w.hit_order == 4'd0 && spot_ok(pkg, pl, wno)) begin
          hit_seen[c] = 1'b1;
          hit_ns[c]   = w.hit_time;
        end
      end
      MODE_SCAN: begin
        for (row = 0; row < PACKAGES * PLANES; row++) begin
          for (x = 2; x + 2 < WIRES; x++) begin
            c = row * WIRES + x;
            if (timed_in_window(c - 2) && timed_in_window(c - 1) &&
                timed_in_window(c + 1) && timed_in_window(c + 2) &&
                hit_ns[c - 2] > hit_ns[c - 1] && hit_ns[c + 2] > hit_ns[c + 1]) begin
              if (trig_tally[c] != '1) trig_tally[c]++;
              if (timed_in_window(c) && fire_tally[c] != '1) fire_tally[c]++;
            end
          end
        end
        foreach (hit_seen[i]) hit_seen[i] = 1'b0;
        res.status = STAT_SCAN;
        owed_results.push_back(res);
      end
      MODE_CLEAR: begin
        foreach (trig_tally[i]) begin
          trig_tally[i] = '0;
          fire_tally[i] = '0;
        end
        res.status = STAT_CLEAR;
        owed_results.push_back(res);
      end
      default: begin
        if (!spot_ok(pkg, pl, wno)) begin
          res.status = STAT_BAD;
        end else begin
          res.status        = STAT_READ;
          res.trigger_count = OUT_W'(trig_tally[c]);
          res.fire_count    = OUT_W'(fire_tally[c]);
          if (trig_tally[c] != 0) trig_reads++;
          if (fire_tally[c] != 0) fire_reads++;
        end
        owed_results.push_back(res);
      end
    endcase
  endtask

  // Random junk in every field, then the given mode
  function automatic in_word_t blank_word(mode_t m);
    logic [63:0] junk;
    in_word_t    w;
    junk   = {$urandom, $urandom};
    w      = junk[$bits(in_word_t)-1:0];
    w.mode = m;
    return w;
  endfunction

  function automatic in_word_t hit_word(int pkg, int pl, int wno, int t);
    in_word_t w;
    w            = blank_word(MODE_STORE);
    w.region_id  = keep_region;
    w.hit_order  = 4'd0;
    w.package_id = PKG_W'(pkg);
    w.plane_id   = PLANE_W'(pl);
    w.wire_id    = WIRE_W'(wno);
    w.hit_time   = TIME_W'(t);
    return w;
  endfunction

  function automatic in_word_t read_word(int pkg, int pl, int wno);
    in_word_t w;
    w            = blank_word(MODE_READ);
    w.package_id = PKG_W'(pkg);
    w.plane_id   = PLANE_W'(pl);
    w.wire_id    = WIRE_W'(wno);
    return w;
  endfunction

  // Point a word at a random wire, or at one with a single index out of range
  function automatic in_word_t place(in_word_t w, bit bad);
    w.package_id = PKG_W'($urandom_range(PACKAGES, 1));
    w.plane_id   = PLANE_W'($urandom_range(PLANES, 1));
    w.wire_id    = WIRE_W'($urandom_range(WIRES, 1));
    if (bad) begin
      case ($urandom_range(2))
        0: w.package_id = $urandom_range(1) ? PKG_W'(0) : PKG_W'($urandom_range(3, PACKAGES + 1));
        1: w.plane_id = $urandom_range(1) ? PLANE_W'(0) : PLANE_W'($urandom_range(7, PLANES + 1));
        default: w.wire_id = $urandom_range(1) ? WIRE_W'(0) : WIRE_W'($urandom_range(511, WIRES + 1));
      endcase
    end
    return w;
  endfunction

  // Mostly inside the window, sometimes on its edges or anywhere
  function automatic int pick_time();
    int span;
    int roll;
    span = int'(win_hi) - int'(win_lo);
    roll = $urandom_range(19);
    if (roll == 0) return int'(win_lo) + int'($urandom_range(1));
    if (roll == 1) return int'(win_hi) - int'($urandom_range(1));
    if (roll == 2 || span < 2) return int'($urandom_range(65535)) - 32768;
    return int'(win_lo) + 1 + int'($urandom_range(span - 2));
  endfunction

  task automatic push_word(in_word_t w);
    pending_words.push_back(w);
    phase_items++;
    case (w.mode)
      MODE_STORE: n_store++;
      MODE_SCAN:  n_scan++;
      MODE_CLEAR: n_clear++;
      default:    n_read++;
    endcase
    budget += 4 * (((w.mode == MODE_SCAN || w.mode == MODE_CLEAR) ? CELLS + 8 : 4) + 64);
  endtask

  // One event: a few tracks across five wires plus noise, then scan and read back
  task automatic queue_event();
    in_word_t reads_due [$];
    in_word_t w;
    int       times [5];
    int       tracks, k, pkg, pl, ctr, wno, n, kind, swap;
    tracks = $urandom_range(6, 1);
    for (k = 0; k < tracks; k++) begin
      pkg = $urandom_range(PACKAGES, 1);
      pl  = $urandom_range(PLANES, 1);
      ctr = $urandom_range(WIRES, 1);
      times[0] = pick_time();
      times[1] = pick_time();
      times[2] = pick_time();
      times[3] = pick_time();
      times[4] = pick_time();
      // outer wires drift longer on most tracks
      if ($urandom_range(9) != 0 && times[0] < times[1]) begin
        swap = times[0]; times[0] = times[1]; times[1] = swap;
      end
      if ($urandom_range(9) != 0 && times[4] < times[3]) begin
        swap = times[4]; times[4] = times[3]; times[3] = swap;
      end
      n = $urandom_range(19);
      if (n < 3) times[2] = int'($urandom_range(65535)) - 32768;
      for (wno = ctr - 2; wno <= ctr + 2; wno++) begin
        if (wno < 1 || wno > WIRES) continue;
        if (wno != ctr && $urandom_range(15) == 0) continue;
        if (wno == ctr && (n == 3 || n == 4)) continue;
        push_word(hit_word(pkg, pl, wno, times[wno - ctr + 2]));
      end
      if ($urandom_range(6) == 0) push_word(hit_word(pkg, pl, ctr, pick_time()));
      reads_due.push_back(read_word(pkg, pl, ctr));
      if ($urandom_range(3) == 0) reads_due.push_back(read_word(pkg, pl, ctr + 1));
      repeat ($urandom_range(3)) begin
        kind = $urandom_range(4);
        w = blank_word(MODE_STORE);
        if (kind != 0) begin
          w.region_id = keep_region;
          w.hit_order = 4'd0;
          w.hit_time  = TIME_W'(pick_time());
          w = place(w, kind == 3);
          if (kind == 1) w.hit_order = 4'($urandom_range(15, 1));
          if (kind == 2) w.region_id = keep_region + 3'($urandom_range(7, 1));
        end
        push_word(w);
      end
    end
    push_word(blank_word(MODE_SCAN));
    if ($urandom_range(19) == 0) push_word(blank_word(MODE_SCAN));
    foreach (reads_due[i]) push_word(reads_due[i]);
    repeat ($urandom_range(2)) push_word(place(blank_word(MODE_READ), $urandom_range(1)));
    if ($urandom_range(11) == 0) begin
      push_word(blank_word(MODE_CLEAR));
      push_word(reads_due[0]);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIN_LO: win_lo = TIME_W'(val);
      REG_WIN_HI: win_hi = TIME_W'(val);
      default:    keep_region = val[2:0];
    endcase
  endtask

  // Drain all words and results, then let a trailing store settle
  task automatic wait_idle();
    budget += 400;
    while (pending_words.size() != 0 || start || owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  always @(negedge clk) begin : drive
    int gap;
    int roll;
    gap = 0;
    // hold a word until the block takes it
    if (rst_n && !(start && !word_taken)) begin
      if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (pending_words.size() != 0) begin
        start   <= 1'b1;
        in_word <= pending_words.pop_front();
        if (steady_left > 0) begin
          steady_left--;
        end else begin
          roll = $urandom_range(99);
          if (roll < 3) steady_left = $urandom_range(120, 40);
          else if (roll < 55) gap = 0;
          else if (roll < 88) gap = $urandom_range(3, 1);
          else if (roll < 97) gap = $urandom_range(12, 4);
          else gap = $urandom_range(60, 20);
        end
        idle_left = gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    out_word_t want;
    word_taken = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (owed_results.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("cycle %0d: result with nothing owed, status %0d", cycles, out_word.status);
        end else begin
          want = owed_results.pop_front();
          if (out_word.status !== want.status ||
              out_word.trigger_count !== want.trigger_count ||
              out_word.fire_count !== want.fire_count) begin
            faults++;
            if (faults <= 10)
              $display("cycle %0d: status %0d/%0d trigger %0d/%0d fire %0d/%0d (exp/act)",
                       cycles, want.status, out_word.status, want.trigger_count,
                       out_word.trigger_count, want.fire_count, out_word.fire_count);
          end
        end
      end else if (out_valid !== 1'b0) begin
        faults++;
        if (faults <= 10) $display("cycle %0d: result strobe unknown", cycles);
      end
      word_taken = start && (busy === 1'b0);
      if (word_taken) advance_counters(in_word);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > budget) begin
      $display("no progress by cycle %0d, %0d results still owed", cycles, owed_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : run
    in_word_t w;
    int       p, lo, hi, region;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < 6; p++) begin
      if (p != 0) wait_idle();
      case (p)
        0: begin lo = -10; hi = 400; region = 3; end
        1: begin lo = -32768; hi = 32767; region = 0; end
        2: begin lo = 100; hi = 101; region = 7; end      // nothing strictly inside
        3: begin lo = 300; hi = -300; region = 5; end     // inverted
        4: begin lo = -500; hi = 1000; region = 2; end
        default: begin
          lo = int'($urandom_range(600)) - 300;
          hi = lo + 2 + int'($urandom_range(700));
          region = $urandom_range(7);
        end
      endcase
      write_reg(REG_WIN_LO, lo);
      write_reg(REG_WIN_HI, hi);
      write_reg(REG_REGION, region);
      settings_done++;
      phase_items = 0;
      if (p == 0) begin
        // wrong region and late hit order are dropped
        w = hit_word(1, 1, 1, 0);
        w.region_id = keep_region + 3'd1;
        push_word(w);
        w = hit_word(1, 1, 2, 40);
        w.hit_order = 4'd15;
        push_word(w);
        // first scanned centre: fires; wire 1 is overwritten to make it well formed
        push_word(hit_word(1, 1, 1, 30));
        push_word(hit_word(1, 1, 2, 40));
        push_word(hit_word(1, 1, 3, 0));
        push_word(hit_word(1, 1, 4, 40));
        push_word(hit_word(1, 1, 5, 50));
        push_word(hit_word(1, 1, 1, 50));
        // last scanned centre sits on the upper bound: triggers without a fire
        push_word(hit_word(PACKAGES, PLANES, WIRES - 4, 30));
        push_word(hit_word(PACKAGES, PLANES, WIRES - 3, 20));
        push_word(hit_word(PACKAGES, PLANES, WIRES - 2, 400));
        push_word(hit_word(PACKAGES, PLANES, WIRES - 1, 20));
        push_word(hit_word(PACKAGES, PLANES, WIRES, 30));
        push_word(hit_word(3, 7, 511, -32768));
        push_word(hit_word(0, 0, 0, 32767));
        push_word(hit_word(1, PLANES + 1, WIRES + 1, -1));
        push_word(blank_word(MODE_SCAN));
        push_word(read_word(1, 1, 3));
        push_word(read_word(PACKAGES, PLANES, WIRES - 2));
        push_word(read_word(1, 1, 2));
        push_word(read_word(0, 1, 1));
        push_word(read_word(1, 1, WIRES + 1));
        push_word(blank_word(MODE_CLEAR));
        push_word(read_word(1, 1, 3));
        push_word(blank_word(MODE_SCAN));
      end
      while (phase_items < PHASE_WORDS) queue_event();
    end
    wait_idle();
    repeat (32) @(posedge clk);
    $display("sent %0d stores, %0d scans, %0d reads and %0d clears under %0d window settings",
             n_store, n_scan, n_read, n_clear, settings_done);
    $display("%0d reads returned a trigger count, %0d a fire count", trig_reads, fire_reads);
    if (faults == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", faults, owed_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
